// ----- src/frpr_pkg.sv -----
// Shared types, constants and the CRC byte update for the framed packet receiver.
`default_nettype none

package frpr_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 7;
    localparam int CRC_W           = 16;
    localparam int DESC_DEPTH      = 2;

    localparam logic [CRC_W-1:0]  CRC_INIT    = 16'h1D0F;
    localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;
    localparam logic [BYTE_W-1:0] START_RESET = 8'hA5;

    // Summary of one completed packet, handed from the parser to the drain side.
    typedef struct packed {
        logic [BYTE_W-1:0] pkt_type;
        logic [LEN_W-1:0]  pkt_length;
        logic              crc_ok;
    } t_desc;

    // Payload buffer write request from the parser.
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [LEN_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
    } t_wr;

    // MSB-first CRC-16 update with one byte.
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/framed_packet_receiver_crc16_core.sv -----
// Top level of the framed packet receiver with CRC-16/AUG-CCITT check.
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  ----------------------------------------
//  input     in         push / full            i_rx_byte
//  result    out        empty / pop            o_pkt_type, o_pkt_length, o_payload_byte,
//                                              o_byte_valid, o_crc_ok, o_last
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_data (start byte)
//
// The parser takes one byte per cycle without interruption while the descriptor
// queue has room; full rises only when two completed packets are waiting to drain.
// Each result goes through a fetch state (payload buffer read), then is shown until pop.
// The first result of a packet also waits in idle while the drain picks up its descriptor.
// Reset is synchronous; the payload buffer needs no clearing pass.
// A stalled result (pop low) never stops the parser until both buffer banks are taken.
`default_nettype none

module framed_packet_receiver_crc16_core
    import frpr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    output logic                   empty,
    input  wire logic              pop,
    output logic [BYTE_W-1:0]      o_pkt_type,
    output logic [LEN_W-1:0]       o_pkt_length,
    output logic [BYTE_W-1:0]      o_payload_byte,
    output logic                   o_byte_valid,
    output logic                   o_crc_ok,
    output logic                   o_last,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [BYTE_W-1:0] i_cfg_data
);

    logic [BYTE_W-1:0] r_start_byte;
    logic              accept;
    t_wr               wr;
    logic              desc_push;
    t_desc             desc_in;
    t_desc             desc_out;
    logic              desc_pop;
    logic              desc_full;
    logic              desc_empty;

    // The start byte register can always be written; the write is registered.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_start_byte <= i_cfg_data;
        end
    end

    // The parser writes into the bank that no queued packet owns. With two banks
    // and two queue entries, a full queue is exactly the case where both banks are
    // in use, so it also stops input transactions.
    assign full   = desc_full;
    assign accept = push && !full;

    frpr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_rx_byte    (i_rx_byte),
        .i_start_byte (r_start_byte),
        .o_wr         (wr),
        .o_desc_push  (desc_push),
        .o_desc       (desc_in)
    );

    frpr_desc_fifo u_desc_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_data  (desc_in),
        .i_pop   (desc_pop),
        .o_data  (desc_out),
        .o_full  (desc_full),
        .o_empty (desc_empty)
    );

    // The drain walks the oldest packet's bank, releasing the descriptor and the
    // bank on the result transaction that carries the last marker.
    frpr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr           (wr),
        .i_desc         (desc_out),
        .i_desc_empty   (desc_empty),
        .o_desc_pop     (desc_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_pkt_type     (o_pkt_type),
        .o_pkt_length   (o_pkt_length),
        .o_payload_byte (o_payload_byte),
        .o_byte_valid   (o_byte_valid),
        .o_crc_ok       (o_crc_ok),
        .o_last         (o_last)
    );

`ifndef NO_ASSERTIONS
    // A completed packet is only handed over when the queue has room for it.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        desc_push |-> !desc_full)
        else $error("descriptor pushed into a full queue");

    // A shown result always belongs to a queued packet.
    a_show_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !desc_empty)
        else $error("result shown without a queued packet");

    // An empty packet is a single result that is also the last one.
    a_empty_pkt_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_byte_valid) |-> o_last)
        else $error("empty packet result without last marker");

    // After reset no result is shown.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result shown right after reset");
`endif

endmodule

`default_nettype wire

// ----- src/frpr_front.sv -----
// Byte parser: start hunt, header, payload store writes and CRC check.
`default_nettype none

module frpr_front
    import frpr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    input  wire logic [BYTE_W-1:0] i_start_byte,
    output t_wr                    o_wr,
    output logic                   o_desc_push,
    output t_desc                  o_desc
);

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_TYPE  = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CRCLO = 3'd4,
        PH_CRCHI = 3'd5
    } t_phase;

    localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_type, n_type;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [BYTE_W-1:0] r_crc_lo, n_crc_lo;
    logic              r_bank, n_bank;
    logic [CRC_W-1:0]  crc_next;

    assign crc_next = crc_feed(r_crc, i_rx_byte);

    always_comb begin
        n_phase     = r_phase;
        n_type      = r_type;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_crc       = r_crc;
        n_crc_lo    = r_crc_lo;
        n_bank      = r_bank;
        o_wr.en     = 1'b0;
        o_wr.bank   = r_bank;
        o_wr.idx    = r_cnt;
        o_wr.data   = i_rx_byte;
        o_desc_push = 1'b0;
        o_desc.pkt_type   = r_type;
        o_desc.pkt_length = r_len;
        o_desc.crc_ok     = ({i_rx_byte, r_crc_lo} == r_crc);

        if (i_accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == i_start_byte) begin
                        n_crc   = crc_next;
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_type  = i_rx_byte;
                    n_crc   = crc_next;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    if (i_rx_byte <= MAX_LEN) begin
                        n_len   = i_rx_byte[LEN_W-1:0];
                        n_crc   = crc_next;
                        n_cnt   = '0;
                        n_phase = (i_rx_byte == '0) ? PH_CRCLO : PH_DATA;
                    end else begin
                        n_phase  = PH_HUNT;
                        n_type   = '0;
                        n_len    = '0;
                        n_cnt    = '0;
                        n_crc    = CRC_INIT;
                        n_crc_lo = '0;
                    end
                end
                PH_DATA: begin
                    o_wr.en = 1'b1;
                    n_crc   = crc_next;
                    n_cnt   = r_cnt + LEN_W'(1);
                    if (n_cnt >= r_len) begin
                        n_phase = PH_CRCLO;
                    end
                end
                PH_CRCLO: begin
                    n_crc_lo = i_rx_byte;
                    n_phase  = PH_CRCHI;
                end
                PH_CRCHI: begin
                    // Packet complete: hand it over and switch payload banks.
                    o_desc_push = 1'b1;
                    n_bank      = ~r_bank;
                    n_phase     = PH_HUNT;
                    n_type      = '0;
                    n_len       = '0;
                    n_cnt       = '0;
                    n_crc       = CRC_INIT;
                    n_crc_lo    = '0;
                end
                default: begin
                    n_phase  = PH_HUNT;
                    n_type   = '0;
                    n_len    = '0;
                    n_cnt    = '0;
                    n_crc    = CRC_INIT;
                    n_crc_lo = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_type   <= '0;
            r_len    <= '0;
            r_cnt    <= '0;
            r_crc    <= CRC_INIT;
            r_crc_lo <= '0;
            r_bank   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
            r_bank   <= n_bank;
        end
    end

endmodule

`default_nettype wire

// ----- src/frpr_desc_fifo.sv -----
// Two-entry queue of completed packet descriptors between parser and drain.
`default_nettype none

module frpr_desc_fifo
    import frpr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_data,
    input  wire logic  i_pop,
    output t_desc      o_data,
    output logic       o_full,
    output logic       o_empty
);

    localparam int PTR_W = $clog2(DESC_DEPTH);
    localparam int CNT_W = $clog2(DESC_DEPTH + 1);

    t_desc             r_mem [DESC_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CNT_W'(DESC_DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/frpr_back.sv -----
// Payload buffer (two banks) and result drain: one result per payload byte, one for an empty packet.
`default_nettype none

module frpr_back
    import frpr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_wr               i_wr,
    input  wire t_desc             i_desc,
    input  wire logic              i_desc_empty,
    output logic                   o_desc_pop,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output logic [BYTE_W-1:0]      o_pkt_type,
    output logic [LEN_W-1:0]       o_pkt_length,
    output logic [BYTE_W-1:0]      o_payload_byte,
    output logic                   o_byte_valid,
    output logic                   o_crc_ok,
    output logic                   o_last
);

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int DEPTH = 2 ** (IDX_W + 1);

    typedef enum logic [1:0] {
        B_IDLE  = 2'd0,
        B_FETCH = 2'd1,
        B_SHOW  = 2'd2
    } t_bstate;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;
    t_bstate           r_state;
    logic [LEN_W-1:0]  r_cnt;
    logic              r_bank;
    logic              is_last;
    logic              take;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.bank, i_wr.idx[IDX_W-1:0]}] <= i_wr.data;
        end
        r_rd_data <= r_mem[{r_bank, r_cnt[IDX_W-1:0]}];
    end

    assign is_last    = ((r_cnt + LEN_W'(1)) >= i_desc.pkt_length);
    assign take       = (r_state == B_SHOW) && i_pop;
    assign o_desc_pop = take && is_last;

    assign o_empty        = (r_state != B_SHOW);
    assign o_pkt_type     = i_desc.pkt_type;
    assign o_pkt_length   = i_desc.pkt_length;
    assign o_byte_valid   = (i_desc.pkt_length != '0);
    assign o_payload_byte = o_byte_valid ? r_rd_data : '0;
    assign o_crc_ok       = i_desc.crc_ok;
    assign o_last         = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_cnt   <= '0;
            r_bank  <= 1'b0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (!i_desc_empty) begin
                        r_cnt   <= '0;
                        r_state <= B_FETCH;
                    end
                end
                B_FETCH: begin
                    r_state <= B_SHOW;
                end
                B_SHOW: begin
                    if (take) begin
                        if (is_last) begin
                            r_bank  <= ~r_bank;
                            r_state <= B_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + LEN_W'(1);
                            r_state <= B_FETCH;
                        end
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- test/tb_framed_packet_receiver_crc16_core.sv -----
// Testbench for the framed packet receiver: directed table, random packets, CRC check.
`timescale 1ns / 100ps

module tb_framed_packet_receiver_crc16_core
    import frpr_pkg::*;
;

    typedef logic [BYTE_W-1:0] t_octet;

    // One expected or observed transaction on the result side.
    typedef struct packed {
        logic [BYTE_W-1:0] pkt_type;
        logic [LEN_W-1:0]  pkt_length;
        logic [BYTE_W-1:0] payload_byte;
        logic              byte_valid;
        logic              crc_ok;
        logic              last;
    } t_frame_result;

    // Where the parser model stands inside a frame.
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LEN,
        PH_DATA,
        PH_CRC_LO,
        PH_CRC_HI
    } t_parse_phase;

    // Kinds of rows in the directed table. The CRC rows take their byte from the
    // running CRC of the parser model, so the table stays readable.
    typedef enum logic [2:0] {
        ROW_RAW,
        ROW_CRC_LO,
        ROW_CRC_HI,
        ROW_CRC_HI_BAD,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind     kind;
        t_octet        value;
        logic          typed;
        t_frame_result want;
    } t_stim_row;

    localparam int CLK_HALF_NS  = 5;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_SETTLE = 8;
    localparam int TAIL_CYCLES  = 20;
    localparam int SEG_ITEMS    = 125;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_NS     = 5_000_000;
    localparam int NUM_ROWS     = 27;

    // The directed part. Typed expectations stand only where the answer is
    // obvious: an empty frame with a good CRC, and a one-byte frame whose CRC
    // high byte is inverted. Every other row is checked against the model.
    t_stim_row dir_rows [NUM_ROWS] = '{
        '{ROW_RAW,        8'hFF, 1'b0, '0},  // not a start byte, ignored
        '{ROW_RAW,        8'hA5, 1'b0, '0},  // start
        '{ROW_RAW,        8'h00, 1'b0, '0},  // type 0
        '{ROW_RAW,        8'h00, 1'b0, '0},  // length 0
        '{ROW_CRC_LO,     8'h00, 1'b0, '0},
        '{ROW_CRC_HI,     8'h00, 1'b1, '{8'h00, 7'd0, 8'h00, 1'b0, 1'b1, 1'b1}},
        '{ROW_RAW,        8'hA5, 1'b0, '0},  // start
        '{ROW_RAW,        8'hFF, 1'b0, '0},  // type 255
        '{ROW_RAW,        8'hA5, 1'b0, '0},  // length too big, not a start either
        '{ROW_RAW,        8'hA5, 1'b0, '0},  // start
        '{ROW_RAW,        8'hFF, 1'b0, '0},
        '{ROW_RAW,        8'h01, 1'b0, '0},  // length 1
        '{ROW_RAW,        8'hFF, 1'b0, '0},
        '{ROW_CRC_LO,     8'h00, 1'b0, '0},
        '{ROW_CRC_HI_BAD, 8'h00, 1'b1, '{8'hFF, 7'd1, 8'hFF, 1'b1, 1'b0, 1'b1}},
        '{ROW_RAW,        8'hA5, 1'b0, '0},  // start
        '{ROW_RAW,        8'h12, 1'b0, '0},  // type
        '{ROW_CFG,        8'h00, 1'b0, '0},  // start byte changes inside the frame
        '{ROW_RAW,        8'h02, 1'b0, '0},
        '{ROW_RAW,        8'h00, 1'b0, '0},
        '{ROW_RAW,        8'h80, 1'b0, '0},
        '{ROW_CRC_LO,     8'h00, 1'b0, '0},
        '{ROW_CRC_HI,     8'h00, 1'b0, '0},
        '{ROW_RAW,        8'h00, 1'b0, '0},  // the new start byte
        '{ROW_RAW,        8'h7E, 1'b0, '0},
        '{ROW_RAW,        8'h41, 1'b0, '0},  // length 65, one above the maximum
        '{ROW_CFG,        8'hFF, 1'b0, '0}
    };

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   push        = 1'b0;
    logic   full;
    t_octet i_rx_byte   = '0;
    logic   empty;
    logic   pop         = 1'b0;
    logic   i_cfg_valid = 1'b0;
    logic   o_cfg_ready;
    t_octet i_cfg_data  = '0;

    t_frame_result seen;

    framed_packet_receiver_crc16_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_rx_byte     (i_rx_byte),
        .empty         (empty),
        .pop           (pop),
        .o_pkt_type    (seen.pkt_type),
        .o_pkt_length  (seen.pkt_length),
        .o_payload_byte(seen.payload_byte),
        .o_byte_valid  (seen.byte_valid),
        .o_crc_ok      (seen.crc_ok),
        .o_last        (seen.last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // Parser model state. It mirrors what the block must hold after each
    // accepted byte.
    t_octet           start_value = START_RESET;
    t_parse_phase     phase       = PH_HUNT;
    t_octet           held_type   = '0;
    logic [LEN_W-1:0] held_len    = '0;
    logic [LEN_W-1:0] data_count  = '0;
    t_octet           frame_store [MAX_PAYLOAD_DEF];
    logic [CRC_W-1:0] crc_acc     = CRC_INIT;
    t_octet           crc_lo_held = '0;

    t_frame_result fresh_results [$];    // Results caused by the latest byte.
    t_frame_result awaited_results [$];  // Results not yet seen on the output.

    int src_idle_pct  = 20;
    int sink_idle_pct = 77;
    int taken_count   = 0;
    int fail_count    = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;

    // Bit-serial CRC-16, most significant bit first.
    function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
                                                      input t_octet b);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            fb = c[CRC_W-1] ^ b[i];
            c  = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
        end
        return c;
    endfunction

    task automatic hunt_restart();
        phase       = PH_HUNT;
        held_type   = '0;
        held_len    = '0;
        data_count  = '0;
        crc_acc     = CRC_INIT;
        crc_lo_held = '0;
    endtask

    // Advance the parser model by one received byte. Frames that complete
    // land in fresh_results. The taken flag is low only for a byte that the
    // hunt skips over.
    task automatic frame_parse(input t_octet b, output bit taken);
        t_frame_result r;
        logic          ok;
        taken = 1'b1;
        fresh_results.delete();
        case (phase)
            PH_HUNT: begin
                if (b == start_value) begin
                    crc_acc = crc16_update(crc_acc, b);
                    phase   = PH_TYPE;
                end else begin
                    taken = 1'b0;
                end
            end
            PH_TYPE: begin
                held_type = b;
                crc_acc   = crc16_update(crc_acc, b);
                phase     = PH_LEN;
            end
            PH_LEN: begin
                if (b <= MAX_PAYLOAD_DEF) begin
                    held_len   = b[LEN_W-1:0];
                    crc_acc    = crc16_update(crc_acc, b);
                    data_count = '0;
                    phase      = (b == 0) ? PH_CRC_LO : PH_DATA;
                end else begin
                    // An oversized length aborts the frame; the byte is not a start.
                    hunt_restart();
                end
            end
            PH_DATA: begin
                frame_store[data_count[5:0]] = b;
                crc_acc    = crc16_update(crc_acc, b);
                data_count = data_count + 1'b1;
                if (data_count >= held_len) begin
                    phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                crc_lo_held = b;
                phase       = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                ok = ({b, crc_lo_held} == crc_acc);
                if (held_len == 0) begin
                    r = '{held_type, '0, '0, 1'b0, ok, 1'b1};
                    fresh_results.push_back(r);
                end else begin
                    for (int k = 0; k < held_len; k++) begin
                        r = '{held_type, held_len, frame_store[k], 1'b1, ok,
                              (k == held_len - 1)};
                        fresh_results.push_back(r);
                    end
                end
                hunt_restart();
            end
            default: hunt_restart();
        endcase
    endtask

    // Offer one byte on the input side, with random idle cycles in front of
    // it, and hold it until the block takes the transaction. Push stays high
    // afterwards so that back-to-back bytes leave no gap.
    task automatic send_byte(input t_octet b, input bit have_typed = 1'b0,
                             input t_frame_result typed = '0);
        bit taken;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        frame_parse(b, taken);
        if (taken) begin
            taken_count++;
        end
        if (have_typed) begin
            awaited_results.push_back(typed);
        end else begin
            foreach (fresh_results[i]) begin
                awaited_results.push_back(fresh_results[i]);
            end
        end
    endtask

    // The start byte register is only written once every expected result has
    // come out and the drain has had time to settle.
    task automatic write_start_byte(input t_octet v);
        @(negedge i_clk);
        push <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        start_value = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One random burst: mostly complete frames with random content, the rest
    // oversized lengths, truncated frames and line noise.
    task automatic send_random_burst();
        int     pick;
        int     len;
        int     cut;
        t_octet mask;
        pick = $urandom_range(0, 99);
        if (pick < 92) begin
            send_byte(start_value);
            send_byte(t_octet'($urandom_range(0, 255)));
            if (pick >= 75 && pick < 85) begin
                send_byte(t_octet'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)));
            end else begin
                len = $urandom_range(0, 99);
                if (len < 8) begin
                    len = MAX_PAYLOAD_DEF;
                end else if (len < 16) begin
                    len = 0;
                end else begin
                    len = $urandom_range(1, 8);
                end
                send_byte(t_octet'(len));
                // A truncated frame stops early, so the next bytes land in its payload or CRC fields.
                cut = (pick >= 85) ? $urandom_range(0, len) : len;
                for (int i = 0; i < cut; i++) begin
                    send_byte(t_octet'($urandom_range(0, 255)));
                end
                if (pick < 75) begin
                    mask = ($urandom_range(0, 99) < 15) ? t_octet'($urandom_range(1, 255)) : '0;
                    if ($urandom_range(0, 1) == 1) begin
                        send_byte(crc_acc[7:0] ^ mask);
                        send_byte(crc_acc[15:8]);
                    end else begin
                        send_byte(crc_acc[7:0]);
                        send_byte(crc_acc[15:8] ^ mask);
                    end
                end
            end
        end else begin
            repeat ($urandom_range(1, 3)) send_byte(t_octet'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_segment(input t_octet start_val, input int src_pct,
                               input int sink_pct, input bit with_hold);
        int goal;
        write_start_byte(start_val);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        if (with_hold) begin
            hold_req = 1'b1;
        end
        goal = taken_count + SEG_ITEMS;
        while (taken_count < goal) begin
            send_random_burst();
        end
    endtask

    // Receiver side. Pop is chosen at each falling edge. A hold request makes
    // the receiver refuse results until the hold count runs out, while the sender
    // keeps offering bytes, so that both buffer banks fill and full rises.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    task automatic compare_field(input string name, input t_octet want, input t_octet got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Each result transaction is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n && pop === 1'b1 && empty === 1'b0) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: type 0x%0h, byte 0x%0h",
                       seen.pkt_type, seen.payload_byte);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                compare_field("pkt_type", want.pkt_type, seen.pkt_type);
                compare_field("pkt_length", t_octet'(want.pkt_length),
                              t_octet'(seen.pkt_length));
                compare_field("payload_byte", want.payload_byte, seen.payload_byte);
                compare_field("byte_valid", t_octet'(want.byte_valid),
                              t_octet'(seen.byte_valid));
                compare_field("crc_ok", t_octet'(want.crc_ok), t_octet'(seen.crc_ok));
                compare_field("last", t_octet'(want.last), t_octet'(seen.last));
            end
        end
    end

    // Main sequence: reset, directed table, then four random segments that
    // walk through the idling modes and several start byte settings.
    initial begin
        hunt_restart();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_RAW:        send_byte(dir_rows[i].value, dir_rows[i].typed,
                                          dir_rows[i].want);
                ROW_CRC_LO:     send_byte(crc_acc[7:0], dir_rows[i].typed,
                                          dir_rows[i].want);
                ROW_CRC_HI:     send_byte(crc_acc[15:8], dir_rows[i].typed,
                                          dir_rows[i].want);
                ROW_CRC_HI_BAD: send_byte(~crc_acc[15:8], dir_rows[i].typed,
                                          dir_rows[i].want);
                ROW_CFG:        write_start_byte(dir_rows[i].value);
                default:        ;
            endcase
        end

        // Sender idles lightly and receiver heavily, then the other way round,
        // then neither idles; the long receiver hold falls in the third segment.
        run_segment(8'hFF, 20, 77, 1'b0);
        run_segment(8'h00, 77, 20, 1'b0);
        run_segment(t_octet'($urandom_range(1, 254)), 0, 0, 1'b1);
        run_segment(START_RESET, 0, 0, 1'b0);

        @(negedge i_clk);
        push <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog for a block that hangs or never drains.
    initial begin
        #LIMIT_NS;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- framed_packet_receiver_crc16_core.f -----
src/frpr_pkg.sv
src/frpr_front.sv
src/frpr_desc_fifo.sv
src/frpr_back.sv
src/framed_packet_receiver_crc16_core.sv
test/tb_framed_packet_receiver_crc16_core.sv
